/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled during reset.
`define LRAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/lrac_pkg.sv */
package lrac_pkg;

  localparam int CordicSteps = 24;
  localparam int XyW         = 24;
  localparam int DistW       = 24;
  localparam int SumW        = 48;
  localparam int RootW       = 24;
  localparam int RingW       = 18;

  localparam logic [1:0] ReqRing   = 2'd0;
  localparam logic [1:0] ReqEdge   = 2'd1;
  localparam logic [1:0] ReqTrack  = 2'd2;
  localparam logic [1:0] ReqShower = 2'd3;

  localparam logic CfgFirstDist = 1'b0;
  localparam logic CfgPitch     = 1'b1;

  typedef logic signed [XyW-1:0] coord_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/layered_ring_acceptance_check_core.sv */
// Channel   Dir  Handshake               Payload
// cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
// request   in   in_valid_i / in_ready_o req_type_i .. spread_slope_i
// result    out  out_valid_o / out_ready_i accepted_o
//
// A load writes its table entry, if the index is in range, and returns to idle. A query
// walks the layers with the 24-step CORDIC unit for a track, adding the square root and
// radial-bin divider for a shower, stopping at the first failing layer.
// One item at a time; a finished result waits in the output register.
// Reset restores the two distance registers; the table memories are not cleared.
module layered_ring_acceptance_check_core #(
  parameter int LAYERS      = 8,
  parameter int PHI_BINS    = 1080,
  parameter int RADIAL_BINS = 200
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic               arm_i,
  input  logic [2:0]         layer_sel_i,
  input  logic [10:0]        phi_bin_i,
  input  logic [7:0]         radial_bin_i,
  input  logic [17:0]        value_outer_i,
  input  logic [17:0]        value_inner_i,
  input  logic signed [19:0] vertex_z_i,
  input  logic signed [21:0] slope_x_i,
  input  logic signed [21:0] slope_y_i,
  input  logic [20:0]        spread_slope_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o
);

  localparam int LayerW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int PbW       = $clog2(PHI_BINS);
  localparam int RbW       = $clog2(RADIAL_BINS);
  localparam int RingDepth = 2 * LAYERS * PHI_BINS;
  localparam int EdgeDepth = RingDepth * RADIAL_BINS;
  localparam int RaW       = $clog2(RingDepth);
  localparam int EaW       = $clog2(EdgeDepth);
  localparam int NumW      = lrac_pkg::RootW + $clog2(RADIAL_BINS + 1);
  localparam int RW        = lrac_pkg::RingW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StLoad = 4'd1;
  localparam logic [3:0] StDist = 4'd2;
  localparam logic [3:0] StMul  = 4'd3;
  localparam logic [3:0] StSq   = 4'd4;
  localparam logic [3:0] StPhi  = 4'd5;
  localparam logic [3:0] StRrd  = 4'd6;
  localparam logic [3:0] StRsq  = 4'd7;
  localparam logic [3:0] StRchk = 4'd8;
  localparam logic [3:0] StSqrt = 4'd9;
  localparam logic [3:0] StDiv  = 4'd10;
  localparam logic [3:0] StErd  = 4'd11;
  localparam logic [3:0] StEchk = 4'd12;
  localparam logic [3:0] StNext = 4'd13;
  localparam logic [3:0] StDone = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [LayerW-1:0] layer_q;
  logic              acc_q, out_valid_q, out_acc_q;
  logic [19:0]       first_dist_q;
  logic [15:0]       pitch_q;

  logic [1:0]         req_q;
  logic               arm_q;
  logic [2:0]         lsel_q;
  logic [10:0]        pbin_q;
  logic [7:0]         rbin_q;
  logic [RW-1:0]      vout_q, vin_q;
  logic signed [19:0] vz_q;
  logic signed [21:0] sx_q, sy_q;
  logic [20:0]        ss_q;

  logic signed [lrac_pkg::DistW-1:0] d_q, d_d, lay_dist_s;
  logic [21:0]                       lay_dist;
  lrac_pkg::coord_t                  x_q, y_q;
  logic signed [45:0]                px, py;
  logic signed [47:0]                xx, yy;
  logic [lrac_pkg::SumW-1:0]         sum_q;
  logic [2*RW-1:0]                   sq_in_q, sq_out_q;
  logic [RaW-1:0]                    ridx_q;
  logic [EaW-1:0]                    eidx_q;
  logic [2*RW-1:0]                   ring_rd_q;
  logic [RW-1:0]                     edge_rd_q;
  logic [RW-1:0]                     rin, rout, span;
  logic                              ring_fail, edge_fail, last_layer;

  logic [31:0] ld_ring32, ld_edge32, q_ring32, q_edge32;
  logic        ld_ok, ring_we, edge_we, ring_re, edge_re;

  logic            cor_start, cor_done;
  logic [PbW-1:0]  cor_bin;
  logic            sq_start, sq_done;
  logic [lrac_pkg::RootW-1:0] root;
  logic            div_start, div_done;
  logic [NumW-1:0] div_num, quo;
  logic [RbW-1:0]  ir;
  logic [lrac_pkg::DistW-1:0] ad;
  logic [44:0]     spread;

  logic [2*RW-1:0] ring_mem [RingDepth];
  logic [RW-1:0]   edge_mem [EdgeDepth];

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_acc_q;

  // per-layer geometry
  assign lay_dist   = 22'(first_dist_q) + 22'(layer_q) * 22'(pitch_q);
  assign lay_dist_s = $signed({2'b00, lay_dist});
  assign d_d        = (arm_q ? lay_dist_s : -lay_dist_s) - lrac_pkg::DistW'(vz_q);
  assign px     = sx_q * d_q;
  assign py     = sy_q * d_q;
  assign xx     = x_q * x_q;
  assign yy     = y_q * y_q;

  assign rin       = ring_rd_q[RW-1:0];
  assign rout      = ring_rd_q[2*RW-1:RW];
  assign span      = rout - rin;
  assign ring_fail = (sum_q < lrac_pkg::SumW'(sq_in_q)) || (sum_q > lrac_pkg::SumW'(sq_out_q));
  assign last_layer = (layer_q == LayerW'(LAYERS - 1));

  // addresses
  assign ld_ok     = (32'(lsel_q) < 32'(LAYERS)) && (32'(pbin_q) < 32'(PHI_BINS));
  assign ld_ring32 = (32'(arm_q) * 32'(LAYERS) + 32'(lsel_q)) * 32'(PHI_BINS) + 32'(pbin_q);
  assign ld_edge32 = ld_ring32 * 32'(RADIAL_BINS) + 32'(rbin_q);
  assign q_ring32  = (32'(arm_q) * 32'(LAYERS) + 32'(layer_q)) * 32'(PHI_BINS) + 32'(cor_bin);
  assign q_edge32  = 32'(ridx_q) * 32'(RADIAL_BINS) + 32'(ir);

  assign ring_we = (state_q == StLoad) && (req_q == lrac_pkg::ReqRing) && ld_ok;
  assign edge_we = (state_q == StLoad) && (req_q == lrac_pkg::ReqEdge) && ld_ok &&
                   (32'(rbin_q) < 32'(RADIAL_BINS));
  assign ring_re = (state_q == StRrd);
  assign edge_re = (state_q == StErd);

  // shower path
  assign div_num = NumW'(root - lrac_pkg::RootW'(rin)) * NumW'(RADIAL_BINS);
  always_comb begin
    if (span == '0) begin
      ir = '0;
    end else if (quo >= NumW'(RADIAL_BINS)) begin
      ir = RbW'(RADIAL_BINS - 1);
    end else begin
      ir = quo[RbW-1:0];
    end
  end
  assign ad        = (d_q < 0) ? -d_q : d_q;
  assign spread    = 45'(ss_q) * 45'(ad);
  assign edge_fail = (spread > 45'({edge_rd_q, 20'd0}));

  assign cor_start = (state_q == StSq);
  assign sq_start  = (state_q == StRchk) && !ring_fail && (req_q == lrac_pkg::ReqShower);
  assign div_start = (state_q == StSqrt) && sq_done;

  lrac_cordic #(.PHI_BINS(PHI_BINS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (x_q),
    .y_i     (y_q),
    .done_o  (cor_done),
    .bin_o   (cor_bin)
  );

  lrac_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sum_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  lrac_div #(.NUM_W(NumW), .DEN_W(RW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ld_ring32[RaW-1:0]] <= {vout_q, vin_q};
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ridx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[ld_edge32[EaW-1:0]] <= vout_q;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[eidx_q];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = req_type_i[1] ? StDist : StLoad;
        end
      end
      StLoad: state_d = StIdle;
      StDist: state_d = StMul;
      StMul:  state_d = StSq;
      StSq:   state_d = StPhi;
      StPhi: begin
        if (cor_done) begin
          state_d = StRrd;
        end
      end
      StRrd:  state_d = StRsq;
      StRsq:  state_d = StRchk;
      StRchk: begin
        if (ring_fail) begin
          state_d = StDone;
        end else if (req_q == lrac_pkg::ReqShower) begin
          state_d = StSqrt;
        end else begin
          state_d = StNext;
        end
      end
      StSqrt: begin
        if (sq_done) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          state_d = StErd;
        end
      end
      StErd:  state_d = StEchk;
      StEchk: state_d = edge_fail ? StDone : StNext;
      StNext: state_d = last_layer ? StDone : StDist;
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      layer_q      <= '0;
      acc_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      first_dist_q <= 20'd208878;
      pitch_q      <= 16'd670;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lrac_pkg::CfgFirstDist: first_dist_q <= cfg_data_i;
          lrac_pkg::CfgPitch:     pitch_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == StIdle) begin
        layer_q <= '0;
        acc_q   <= 1'b1;
      end
      if ((state_q == StRchk && ring_fail) || (state_q == StEchk && edge_fail)) begin
        acc_q <= 1'b0;
      end
      if (state_q == StNext && !last_layer) begin
        layer_q <= layer_q + LayerW'(1);
      end
      if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      req_q  <= req_type_i;
      arm_q  <= arm_i;
      lsel_q <= layer_sel_i;
      pbin_q <= phi_bin_i;
      rbin_q <= radial_bin_i;
      vout_q <= value_outer_i;
      vin_q  <= value_inner_i;
      vz_q   <= vertex_z_i;
      sx_q   <= slope_x_i;
      sy_q   <= slope_y_i;
      ss_q   <= spread_slope_i;
    end
    if (state_q == StDist) begin
      d_q <= d_d;
    end
    if (state_q == StMul) begin
      x_q <= px[43:20];
      y_q <= py[43:20];
    end
    if (state_q == StSq) begin
      sum_q <= $unsigned(xx) + $unsigned(yy);
    end
    if (state_q == StPhi && cor_done) begin
      ridx_q <= q_ring32[RaW-1:0];
    end
    if (state_q == StRsq) begin
      sq_in_q  <= (2*RW)'(rin) * (2*RW)'(rin);
      sq_out_q <= (2*RW)'(rout) * (2*RW)'(rout);
    end
    if (state_q == StDiv && div_done) begin
      eidx_q <= q_edge32[EaW-1:0];
    end
    if (state_q == StDone && (!out_valid_q || out_ready_i)) begin
      out_acc_q <= acc_q;
    end
  end

endmodule

/* rtl/lrac_cordic.sv */
module lrac_cordic #(
  parameter int PHI_BINS = 1080,
  localparam int PbW = $clog2(PHI_BINS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  lrac_pkg::coord_t    x_i,
  input  lrac_pkg::coord_t    y_i,
  output logic                done_o,
  output logic [PbW-1:0]      bin_o
);

  localparam int CW = 27;
  localparam int ZW = 36;
  localparam int TW = 33;
  localparam int PW = TW + PbW + 1;

  logic signed [CW-1:0] xs, ys, cx_q, cy_q, dx, dy;
  logic signed [ZW-1:0] z_q, base_q, t;
  logic signed [ZW-1:0] ang;
  logic [4:0]           step_q;
  logic                 busy_q, fin_q, done_q;
  logic [PbW-1:0]       bin_q;
  logic [TW-1:0]        tc;
  logic [PW-1:0]        prod;
  logic [PbW:0]         braw;

  assign xs  = CW'(x_i);
  assign ys  = CW'(y_i);
  assign dx  = cy_q >>> step_q;
  assign dy  = cx_q >>> step_q;
  assign ang = $signed({{(ZW-30){1'b0}}, lrac_pkg::atan_turn(step_q)});
  assign t   = base_q + z_q;

  always_comb begin
    if (t < 0) begin
      tc = '0;
    end else if (t > $signed(ZW'(64'd1 << 32))) begin
      tc = TW'(64'd1 << 32);
    end else begin
      tc = t[TW-1:0];
    end
  end

  assign prod = PW'(tc) * PW'(PHI_BINS);
  assign braw = prod[32 +: PbW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= (ys != 0);
      fin_q  <= (ys == 0);
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 5'd1;
      if (step_q == 5'(lrac_pkg::CordicSteps - 1)) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      z_q <= '0;
      if (xs < 0) begin
        base_q <= (ys >= 0) ? $signed(ZW'(64'd1 << 32)) : '0;
        cx_q   <= -xs;
        cy_q   <= -ys;
      end else begin
        base_q <= $signed(ZW'(64'd1 << 31));
        cx_q   <= xs;
        cy_q   <= ys;
      end
    end else if (busy_q) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        z_q  <= z_q + ang;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        z_q  <= z_q - ang;
      end
    end else if (fin_q) begin
      bin_q <= (braw >= (PbW+1)'(PHI_BINS)) ? PbW'(PHI_BINS - 1) : braw[PbW-1:0];
    end
  end

  assign done_o = done_q;
  assign bin_o  = bin_q;

endmodule

/* rtl/lrac_isqrt.sv */
module lrac_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lrac_pkg::SumW-1:0]     val_i,
  output logic                          done_o,
  output logic [lrac_pkg::RootW-1:0]    root_o
);

  localparam int W = lrac_pkg::SumW;

  logic [W-1:0] v_q, res_q, bit_q;
  logic [W:0]   trial;
  logic         busy_q, done_q;

  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && bit_q == W'(1)) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_q   <= v_q - trial[W-1:0];
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[lrac_pkg::RootW-1:0];

endmodule

/* rtl/lrac_div.sv */
module lrac_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 18
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   shifted, diff;
  logic             ge;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/lrac_checker.sv */
`include "assert_macros.svh"

module lrac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic accepted_o
);

  `LRAC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `LRAC_ASSERT_NXT(a_acc_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(accepted_o))
  `LRAC_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `LRAC_ASSERT_IMP(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))

endmodule

bind layered_ring_acceptance_check_core lrac_checker u_lrac_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o)
);

/* tb/sv/layered_ring_acceptance_check_core_tb.sv */
`timescale 1ns / 1ps

module layered_ring_acceptance_check_core_tb;

  typedef struct {
    logic [1:0]         req;
    logic               arm;
    logic [2:0]         layer;
    logic [10:0]        phi;
    logic [7:0]         rbin;
    logic [17:0]        vout;
    logic [17:0]        vin;
    logic signed [19:0] vz;
    logic signed [21:0] sx;
    logic signed [21:0] sy;
    logic [20:0]        ss;
  } word_t;

  localparam int NLayers = 8;
  localparam int NPhi    = 1080;
  localparam int NRad    = 200;
  localparam int MissNone = 0;
  localparam int MissRing = 1;
  localparam int MissEdge = 2;

  class acceptance_sb;
    longint first_dist;
    longint pitch;
    longint outer_tab[int];
    longint inner_tab[int];
    longint edge_tab[int];
    bit     accept_q[$];
    int     errors;
    longint atan_tab[24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81};

    function new();
      first_dist = 208878;
      pitch      = 670;
      errors     = 0;
    endfunction

    function longint azimuth_bin(longint x, longint y);
      longint base, z, dx, dy, t;
      base = 64'sd1 <<< 31;
      z = 0;
      if (x < 0) begin
        base = (y >= 0) ? (64'sd1 <<< 32) : 0;
        x = -x;
        y = -y;
      end
      if (y != 0) begin
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y > 0) begin
            x += dx; y -= dy; z += atan_tab[i];
          end else begin
            x -= dx; y += dy; z -= atan_tab[i];
          end
        end
      end
      t = base + z;
      if (t < 0) t = 0;
      if (t > (64'sd1 <<< 32)) t = 64'sd1 <<< 32;
      t = (t * NPhi) >>> 32;
      if (t >= NPhi) t = NPhi - 1;
      return t;
    endfunction

    function longint root_floor(longint v);
      longint res, b;
      res = 0;
      b = 64'sd1 <<< 60;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >>> 1) + b;
        end else begin
          res = res >>> 1;
        end
        b = b >>> 2;
      end
      return res;
    endfunction

    // walk the layers; stop at a failure or at a table entry not yet loaded
    function void evaluate(input word_t w, output bit pass, output int miss,
                           output int m_layer, output int m_phi, output int m_rbin,
                           output longint m_r, output longint m_thr);
      longint lay_dist, d, ad, x, y, sum, phi, rmin, rmax, r, span, ir, ev;
      int ri, ei;
      pass = 0; miss = MissNone; m_layer = 0; m_phi = 0; m_rbin = 0; m_r = 0; m_thr = 0;
      for (int l = 0; l < NLayers; l++) begin
        lay_dist = first_dist + l * pitch;
        d = (w.arm ? lay_dist : -lay_dist) - longint'(w.vz);
        ad = (d < 0) ? -d : d;
        x = (longint'(w.sx) * d) >>> 20;
        y = (longint'(w.sy) * d) >>> 20;
        sum = x * x + y * y;
        phi = azimuth_bin(x, y);
        ri = (int'(w.arm) * NLayers + l) * NPhi + int'(phi);
        r = root_floor(sum);
        if (!outer_tab.exists(ri)) begin
          miss = MissRing; m_layer = l; m_phi = int'(phi); m_r = r;
          return;
        end
        rmin = inner_tab[ri];
        rmax = outer_tab[ri];
        if (sum < rmin * rmin || sum > rmax * rmax) return;
        if (w.req == lrac_pkg::ReqShower) begin
          span = rmax - rmin;
          ir = 0;
          if (span != 0) ir = ((r - rmin) * NRad) / span;
          if (ir >= NRad) ir = NRad - 1;
          ei = ri * NRad + int'(ir);
          if (!edge_tab.exists(ei)) begin
            miss = MissEdge; m_layer = l; m_phi = int'(phi); m_rbin = int'(ir);
            m_thr = (longint'(w.ss) * ad) >>> 20;
            return;
          end
          ev = edge_tab[ei];
          if (longint'(w.ss) * ad > (ev <<< 20)) return;
        end
      end
      pass = 1;
    endfunction

    function void note(word_t w);
      int ri, miss, ml, mp, mr;
      bit pass;
      longint r, thr;
      ri = (int'(w.arm) * NLayers + int'(w.layer)) * NPhi + int'(w.phi);
      if (w.req == lrac_pkg::ReqRing) begin
        if (w.phi < NPhi) begin
          outer_tab[ri] = longint'(w.vout);
          inner_tab[ri] = longint'(w.vin);
        end
      end else if (w.req == lrac_pkg::ReqEdge) begin
        if (w.phi < NPhi && w.rbin < NRad) begin
          edge_tab[ri * NRad + int'(w.rbin)] = longint'(w.vout);
        end
      end else begin
        evaluate(w, pass, miss, ml, mp, mr, r, thr);
        if (miss != MissNone) begin
          errors++;
          $display("%0t: query reads an unloaded table entry", $time);
        end
        accept_q.push_back(pass);
      end
    endfunction

    function void check(bit act);
      bit exp_v;
      if (accept_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual accepted=%0b", $time, act);
        return;
      end
      exp_v = accept_q.pop_front();
      if (exp_v !== act) begin
        errors++;
        $display("%0t: accepted mismatch, expected %0b, actual %0b", $time, exp_v, act);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [19:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         req_type_i;
  logic               arm_i;
  logic [2:0]         layer_sel_i;
  logic [10:0]        phi_bin_i;
  logic [7:0]         radial_bin_i;
  logic [17:0]        value_outer_i;
  logic [17:0]        value_inner_i;
  logic signed [19:0] vertex_z_i;
  logic signed [21:0] slope_x_i;
  logic signed [21:0] slope_y_i;
  logic [20:0]        spread_slope_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               accepted_o;

  layered_ring_acceptance_check_core uut (.*);

  acceptance_sb sb = new();
  int send_idle  = 0;
  int recv_stall = 0;
  bit hold_req   = 0;
  int sent       = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check(accepted_o);
      if (hold_req && hold_cnt == 0) hold_cnt = 400;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_req = 0;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  task automatic send_word(word_t w);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < send_idle) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= w.req;
    arm_i          <= w.arm;
    layer_sel_i    <= w.layer;
    phi_bin_i      <= w.phi;
    radial_bin_i   <= w.rbin;
    value_outer_i  <= w.vout;
    value_inner_i  <= w.vin;
    vertex_z_i     <= w.vz;
    slope_x_i      <= w.sx;
    slope_y_i      <= w.sy;
    spread_slope_i <= w.ss;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note(w);
    sent++;
  endtask

  function automatic logic [17:0] clamp18(longint v);
    if (v < 0) return '0;
    if (v > 262143) return 18'h3FFFF;
    return v[17:0];
  endfunction

  // load whatever table entries the query will read, then send it
  task automatic run_query(word_t q);
    word_t ld;
    bit pass;
    int miss, ml, mp, mr, k;
    longint r, thr;
    for (int n = 0; n < 40; n++) begin
      sb.evaluate(q, pass, miss, ml, mp, mr, r, thr);
      if (miss == MissNone) break;
      ld = q;
      ld.arm = q.arm;
      ld.layer = 3'(ml);
      ld.phi = 11'(mp);
      ld.rbin = 8'(mr);
      k = int'($urandom_range(0, 19));
      if (miss == MissRing) begin
        ld.req = lrac_pkg::ReqRing;
        case (k)
          0: begin
            ld.vin = clamp18(r + 1 + longint'($urandom_range(0, 50)));
            ld.vout = clamp18(r);
          end
          1: begin ld.vin = clamp18(r); ld.vout = clamp18(r); end
          2: begin
            ld.vout = clamp18(r);
            ld.vin = clamp18(r - longint'($urandom_range(0, 3000)));
          end
          3: begin ld.vin = clamp18(r + 2); ld.vout = clamp18(r + 500); end
          default: begin
            ld.vin  = clamp18(r - longint'($urandom_range(0, 20000)));
            ld.vout = clamp18(r + 1 + longint'($urandom_range(0, 20000)));
          end
        endcase
      end else begin
        ld.req = lrac_pkg::ReqEdge;
        case (k)
          0: ld.vout = clamp18(thr - 1);
          1: ld.vout = clamp18(thr);
          default: ld.vout = clamp18(thr + longint'($urandom_range(0, 5000)));
        endcase
      end
      send_word(ld);
    end
    send_word(q);
  endtask

  function automatic word_t rand_word();
    word_t w;
    longint lim, v;
    w.req   = 2'($urandom_range(0, 3));
    w.arm   = 1'($urandom_range(0, 1));
    w.layer = 3'($urandom_range(0, 7));
    w.phi   = 11'($urandom_range(0, 2047));
    w.rbin  = 8'($urandom_range(0, 255));
    w.vout  = 18'($urandom_range(0, 262143));
    w.vin   = 18'($urandom_range(0, 262143));
    w.vz    = 20'($urandom_range(0, 1048575));
    lim = ($urandom_range(0, 9) < 7) ? 262144 : 1048576;
    v = longint'($urandom_range(0, 2 * lim)) - lim;
    w.sx = v[21:0];
    v = longint'($urandom_range(0, 2 * lim)) - lim;
    w.sy = v[21:0];
    w.ss = 21'($urandom_range(0, 1048576));
    return w;
  endfunction

  task automatic write_cfg(logic idx, logic [19:0] data);
    in_valid_i <= 1'b0;
    while (sb.accept_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lrac_pkg::CfgFirstDist) sb.first_dist = longint'(data);
    else sb.pitch = longint'(data[15:0]);
  endtask

  task automatic directed_part();
    word_t w;
    w = rand_word();
    w.req = lrac_pkg::ReqTrack; w.sx = '0; w.sy = '0; w.vz = '0; w.arm = 1'b1;
    run_query(w);
    w.sx = -22'sd1048576; w.sy = '0;
    run_query(w);
    w.req = lrac_pkg::ReqShower; w.sx = 22'sd1048576; w.sy = 22'sd1048576; w.ss = '0;
    w.vz = 20'sh7FFFF;
    run_query(w);
    w.ss = 21'd1048576; w.vz = -20'sh80000; w.arm = 1'b0;
    run_query(w);
    w.sx = 22'sd300; w.sy = -22'sd1048576; w.ss = 21'd1;
    run_query(w);
    w.req = lrac_pkg::ReqTrack; w.sx = -22'sd5000; w.sy = 22'sd4000;
    run_query(w);
    w.req = lrac_pkg::ReqRing; w.phi = 11'd1080; w.vin = '0; w.vout = 18'h3FFFF;
    send_word(w);
    w.phi = 11'd2047;
    send_word(w);
    w.req = lrac_pkg::ReqEdge; w.phi = 11'd3; w.rbin = 8'd200;
    send_word(w);
    w.rbin = 8'd255; w.vout = '0;
    send_word(w);
    w.phi = 11'd1080; w.rbin = '0;
    send_word(w);
    w.req = lrac_pkg::ReqRing; w.phi = '0; w.layer = 3'd7; w.vin = 18'h3FFFF; w.vout = '0;
    send_word(w);
    for (int i = 0; i < 8; i++) begin
      w = rand_word();
      w.req = (i % 2) ? lrac_pkg::ReqShower : lrac_pkg::ReqTrack;
      run_query(w);
    end
  endtask

  initial begin
    word_t w;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = '0; arm_i = 1'b0; layer_sel_i = '0; phi_bin_i = '0; radial_bin_i = '0;
    value_outer_i = '0; value_inner_i = '0; vertex_z_i = '0;
    slope_x_i = '0; slope_y_i = '0; spread_slope_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_part();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_cfg(lrac_pkg::CfgFirstDist, 20'd0);
          write_cfg(lrac_pkg::CfgPitch, 20'd0);
        end
        2: begin
          write_cfg(lrac_pkg::CfgFirstDist, 20'hFFFFF);
          write_cfg(lrac_pkg::CfgPitch, 20'hFFFF);
        end
        3: begin
          write_cfg(lrac_pkg::CfgFirstDist, 20'($urandom_range(0, 1048575)));
          write_cfg(lrac_pkg::CfgPitch, 20'($urandom_range(0, 65535)));
        end
        4: write_cfg(lrac_pkg::CfgPitch, 20'd0);
        5: begin
          write_cfg(lrac_pkg::CfgFirstDist, 20'd208878);
          write_cfg(lrac_pkg::CfgPitch, 20'd670);
        end
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 81; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 81; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      if (ph == 2) hold_req = 1;
      while (sent < 550 * (ph + 1) / 6) begin
        w = rand_word();
        if (w.req == lrac_pkg::ReqRing || w.req == lrac_pkg::ReqEdge) begin
          if ($urandom_range(0, 3) == 0) send_word(w);
          else begin
            w.req = $urandom_range(0, 1) ? lrac_pkg::ReqTrack : lrac_pkg::ReqShower;
            run_query(w);
          end
        end else begin
          run_query(w);
        end
      end
    end
    in_valid_i <= 1'b0;
    while (sb.accept_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.accept_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
